### src/sbpr_pkg.sv
// Shared types and constants for the byte pattern replace block.
package sbpr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PAT_W    = 64;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MATCH_PATTERN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_PATTERN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 2'd2;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_stream;
  } in_word_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_run;
    logic              stream_done;
    logic [CNT_W-1:0]  replacements_made;
  } out_word_t;

  // Run of bytes handed from the matcher to the emitter
  typedef struct packed {
    logic              load;
    logic [PAT_W-1:0]  pat;
    logic [LEN_W-1:0]  n_pat;
    logic              tail;
    logic [BYTE_W-1:0] tail_byte;
    logic              eos;
  } run_cmd_t;

endpackage

### src/sbpr_matcher.sv
// Configuration registers, partial-match tracking and replacement counter.
module sbpr_matcher import sbpr_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_wdata,
  input  logic                 accept,
  input  in_word_t             in_word,
  output run_cmd_t             cmd,
  output logic [CNT_W-1:0]     total
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

  logic [PAT_W-1:0]  match_r, match_nxt;
  logic [PAT_W-1:0]  repl_r, repl_nxt;
  logic [LEN_W-1:0]  plen_r, plen_nxt;
  logic [IDX_W-1:0]  ms_r, ms_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;

  logic [LEN_W-1:0]  len_eff;
  logic [IDX_W-1:0]  idx;
  logic [LEN_W-1:0]  idx1;
  logic [BYTE_W-1:0] pbyte;
  logic              hit;
  logic              complete;

  always_comb begin
    if (plen_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (plen_r > MAX_LEN) begin
      len_eff = MAX_LEN;
    end else begin
      len_eff = plen_r;
    end
  end

  // Drop a stale index left by a shorter length
  assign idx      = ({1'b0, ms_r} >= len_eff) ? '0 : ms_r;
  assign idx1     = {1'b0, idx} + LEN_W'(1);
  assign pbyte    = match_r[{idx, 3'b000} +: BYTE_W];
  assign hit      = (in_word.data_byte == pbyte);
  assign complete = hit && (idx1 == len_eff);

  always_comb begin
    cmd.pat       = complete ? repl_r : match_r;
    cmd.tail      = !hit;
    cmd.tail_byte = in_word.data_byte;
    cmd.eos       = in_word.end_of_stream;
    if (complete) begin
      cmd.n_pat = len_eff;
    end else if (hit) begin
      cmd.n_pat = in_word.end_of_stream ? idx1 : '0;
    end else begin
      cmd.n_pat = {1'b0, idx};
    end
    cmd.load = accept && ((cmd.n_pat != '0) || cmd.tail);
  end

  always_comb begin
    match_nxt = match_r;
    repl_nxt  = repl_r;
    plen_nxt  = plen_r;
    ms_nxt    = ms_r;
    total_nxt = total_r;
    if (accept) begin
      if (complete || !hit || in_word.end_of_stream) begin
        ms_nxt = '0;
      end else begin
        ms_nxt = idx1[IDX_W-1:0];
      end
      if (complete && (total_r != '1)) begin
        total_nxt = total_r + CNT_W'(1);
      end
    end
    if (cfg_wr_en) begin
      case (cfg_index)
        REG_MATCH_PATTERN: begin
          match_nxt = cfg_wdata;
          ms_nxt    = '0;
        end
        REG_REPLACE_PATTERN: begin
          repl_nxt = cfg_wdata;
        end
        REG_PATTERN_LENGTH: begin
          plen_nxt = cfg_wdata[LEN_W-1:0];
          ms_nxt   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= '0;
      repl_r  <= '0;
      plen_r  <= LEN_W'(1);
      ms_r    <= '0;
      total_r <= '0;
    end else begin
      match_r <= match_nxt;
      repl_r  <= repl_nxt;
      plen_r  <= plen_nxt;
      ms_r    <= ms_nxt;
      total_r <= total_nxt;
    end
  end

  assign total = total_r;

endmodule

### src/sbpr_emitter.sv
// Byte shift register playing out a run, one word per cycle unless stalled, into od_r.
module sbpr_emitter import sbpr_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  run_cmd_t         cmd,
  input  logic [CNT_W-1:0] total,
  output logic             busy,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data
);

  logic [PAT_W-1:0]  sh_r, sh_nxt;
  logic [LEN_W-1:0]  cnt_r, cnt_nxt;
  logic              tail_r, tail_nxt;
  logic [BYTE_W-1:0] tbyte_r, tbyte_nxt;
  logic              eos_r, eos_nxt;
  logic              ov_r, ov_nxt;
  out_word_t         od_r, od_nxt;
  logic              take;
  logic              last;

  assign busy = (cnt_r != '0) || tail_r;
  assign take = !ov_r || out_ready;
  assign last = (cnt_r == '0) || ((cnt_r == LEN_W'(1)) && !tail_r);

  always_comb begin
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    tail_nxt  = tail_r;
    tbyte_nxt = tbyte_r;
    eos_nxt   = eos_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    if (busy && take) begin
      ov_nxt                   = 1'b1;
      od_nxt.last_of_run       = last;
      od_nxt.stream_done       = last && eos_r;
      od_nxt.replacements_made = total;
      if (cnt_r != '0) begin
        od_nxt.out_byte = sh_r[BYTE_W-1:0];
        sh_nxt          = sh_r >> BYTE_W;
        cnt_nxt         = cnt_r - LEN_W'(1);
      end else begin
        od_nxt.out_byte = tbyte_r;
        tail_nxt        = 1'b0;
      end
    end else if (take) begin
      ov_nxt = 1'b0;
    end
    // Only accepted while idle, so a load never meets a run in progress
    if (cmd.load) begin
      sh_nxt    = cmd.pat;
      cnt_nxt   = cmd.n_pat;
      tail_nxt  = cmd.tail;
      tbyte_nxt = cmd.tail_byte;
      eos_nxt   = cmd.eos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      tail_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      tail_r <= tail_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r    <= sh_nxt;
    tbyte_r <= tbyte_nxt;
    eos_r   <= eos_nxt;
    od_r    <= od_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

### src/stream_byte_pattern_replace.sv
// Streaming byte pattern find-and-replace, top level.
// An accepted input word's run is loaded into the emitter shift register and
// played out through the output register; an input giving no output word does
// not hold the input, one giving n words (1..8) holds it while its run plays out.
// Reset (synchronous, active low): match index, counter and run cleared,
// patterns zero, pattern length one.
module stream_byte_pattern_replace import sbpr_pkg::*; #(
  parameter int unsigned MAX_PATTERN_BYTES = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PAT_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_word_t            out_data
);

  run_cmd_t         cmd;
  logic [CNT_W-1:0] total;
  logic             busy;
  logic             accept;

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;

  sbpr_matcher #(
    .MAX_PATTERN_BYTES(MAX_PATTERN_BYTES)
  ) u_matcher (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_word   (in_data),
    .cmd       (cmd),
    .total     (total)
  );

  sbpr_emitter u_emitter (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .total     (total),
    .busy      (busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/stream_byte_pattern_replace_test.sv
// Self-checking testbench for the streaming byte pattern replace block.
module stream_byte_pattern_replace_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sbpr_pkg::*;

  localparam int MAX_BYTES = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_PERIODIC, READY_SPARSE} ready_style_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [PAT_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_word_t            out_data;

  stream_byte_pattern_replace #(.MAX_PATTERN_BYTES(MAX_BYTES)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Mirror of the block's registers and match state
  logic [PAT_W-1:0] find_bytes  = '0;
  logic [PAT_W-1:0] swap_bytes  = '0;
  logic [LEN_W-1:0] len_field   = 4'd1;
  int               hit_depth   = 0;
  logic [CNT_W-1:0] swap_count  = '0;
  out_word_t        pending_words[$];

  int errors         = 0;
  int words_checked  = 0;
  int bytes_sent     = 0;
  int streams_closed = 0;
  int settings_used  = 1;
  int burst_left     = 0;

  logic [31:0]  stall_tick = '0;
  ready_style_t stall_mode = READY_ALWAYS;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("stream_byte_pattern_replace verification failed");
    $finish;
  end

  function automatic int effective_length(input logic [LEN_W-1:0] raw);
    if (raw < 1) return 1;
    if (raw > MAX_BYTES) return MAX_BYTES;
    return int'(raw);
  endfunction

  // Work out the words one input byte gives and queue them
  function automatic void predict_run(input logic [BYTE_W-1:0] b, input logic eos);
    logic [BYTE_W-1:0] emitted[$];
    out_word_t w;
    int n;
    int pos;
    int i;
    n = effective_length(len_field);
    pos = hit_depth;
    if (pos >= n) pos = 0;
    if (b == find_bytes[pos*8 +: 8]) begin
      pos++;
      if (pos == n) begin
        for (i = 0; i < n; i++) emitted.push_back(swap_bytes[i*8 +: 8]);
        pos = 0;
        if (swap_count != '1) swap_count++;
      end
    end else begin
      // the breaking byte is not tried as the start of a new match
      for (i = 0; i < pos; i++) emitted.push_back(find_bytes[i*8 +: 8]);
      pos = 0;
      emitted.push_back(b);
    end
    if (eos) begin
      for (i = 0; i < pos; i++) emitted.push_back(find_bytes[i*8 +: 8]);
      pos = 0;
      streams_closed++;
    end
    hit_depth = pos;
    for (i = 0; i < emitted.size(); i++) begin
      w.out_byte          = emitted[i];
      w.last_of_run       = (i == emitted.size() - 1);
      w.stream_done       = eos && (i == emitted.size() - 1);
      w.replacements_made = swap_count;
      pending_words.push_back(w);
    end
  endfunction

  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eos);
    in_word_t w;
    int gap;
    w.data_byte     = b;
    w.end_of_stream = eos;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    predict_run(b, eos);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    // allow for a byte still in flight that yields no word
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAT_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_MATCH_PATTERN: begin
        find_bytes = value;
        hit_depth  = 0;
      end
      REG_REPLACE_PATTERN: swap_bytes = value;
      REG_PATTERN_LENGTH: begin
        len_field = value[LEN_W-1:0];
        hit_depth = 0;
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // zero pattern of one byte swaps zero for zero and counts it
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
  endtask

  task automatic test_partial_and_break();
    wait_idle();
    write_reg(REG_MATCH_PATTERN, 64'h0000_0000_4433_2211);
    write_reg(REG_REPLACE_PATTERN, 64'h0000_0000_DDCC_BBAA);
    write_reg(REG_PATTERN_LENGTH, 64'd4);
    settings_used++;
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h33, 1'b0);
    send_byte(8'h44, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h33, 1'b1);
    // end of stream inside a partial match flushes it
    send_byte(8'h11, 1'b0);
    send_byte(8'h22, 1'b1);
  endtask

  task automatic test_length_limits();
    int i;
    wait_idle();
    write_reg(REG_MATCH_PATTERN, 64'hFF00_FF00_FF00_FF00);
    write_reg(REG_REPLACE_PATTERN, 64'h00FF_00FF_00FF_00FF);
    // low nibble of fifteen clamps to eight bytes
    write_reg(REG_PATTERN_LENGTH, '1);
    settings_used++;
    for (i = 0; i < MAX_BYTES; i++) send_byte(find_bytes[i*8 +: 8], i == MAX_BYTES - 1);
    wait_idle();
    // length zero acts as one
    write_reg(REG_PATTERN_LENGTH, '0);
    settings_used++;
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_reconfig_drop();
    wait_idle();
    write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0030_2010);
    write_reg(REG_REPLACE_PATTERN, 64'h0000_0000_00C0_B0A0);
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    settings_used++;
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    wait_idle();
    // a new replacement keeps the partial match
    write_reg(REG_REPLACE_PATTERN, 64'h0000_0000_00F3_F2F1);
    send_byte(8'h30, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'h20, 1'b0);
    wait_idle();
    write_reg(REG_MATCH_PATTERN, 64'h0000_0000_0030_2010);
    send_byte(8'h30, 1'b0);
    send_byte(8'h10, 1'b0);
    wait_idle();
    // unused index must leave everything alone
    write_reg(REG_SPARE, '1);
    send_byte(8'h20, 1'b0);
    wait_idle();
    write_reg(REG_PATTERN_LENGTH, 64'd3);
    send_byte(8'h30, 1'b1);
  endtask

  task automatic test_random_streams();
    logic [PAT_W-1:0] m;
    logic [PAT_W-1:0] r;
    logic [PAT_W-1:0] lw;
    logic [LEN_W-1:0] l;
    int phase;
    int goal;
    int n;
    int cut;
    int i;
    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          m = '0;
          r = '1;
          l = 4'd1;
        end
        1: begin
          m = '1;
          r = '0;
          l = 4'd8;
        end
        2: begin
          // two-letter alphabet makes overlapping occurrences common
          for (i = 0; i < MAX_BYTES; i++) m[i*8 +: 8] = $urandom_range(0, 1) ? 8'h5A : 8'hA5;
          r = {$urandom, $urandom};
          l = LEN_W'($urandom_range(2, 8));
        end
        default: begin
          m = {$urandom, $urandom};
          r = {$urandom, $urandom};
          l = LEN_W'($urandom_range(0, 15));
        end
      endcase
      lw = {$urandom, $urandom};
      lw[LEN_W-1:0] = l;
      write_reg(REG_MATCH_PATTERN, m);
      write_reg(REG_REPLACE_PATTERN, r);
      write_reg(REG_PATTERN_LENGTH, lw);
      if ($urandom_range(0, 1) != 0) write_reg(REG_SPARE, {$urandom, $urandom});
      settings_used++;
      n = effective_length(l);
      goal = bytes_sent + 50;
      while (bytes_sent < goal) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // pattern prefix, complete most of the time, else broken off
            cut = ($urandom_range(0, 2) != 0) ? n : $urandom_range(1, n);
            for (i = 0; i < cut; i++) send_byte(m[i*8 +: 8], $urandom_range(0, 19) == 0);
            if (cut < n) send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
          end
          6, 7, 8: send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
          default: begin
            if ($urandom_range(0, 3) == 0) wait_idle();
            else send_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
          end
        endcase
      end
    end
  endtask

  // Receiver stall pattern, restyled whenever the low six bits of stall_tick are zero
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[5:0] == '0) stall_mode <= ready_style_t'($urandom_range(0, 3));
    case (stall_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_MOSTLY:   out_ready <= ($urandom_range(0, 99) < 70);
      READY_PERIODIC: out_ready <= (stall_tick[2:0] > 3'd2);
      default:        out_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin : check_words
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $error("unexpected word: out_byte %02h", out_data.out_byte);
        errors++;
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_data.out_byte);
          errors++;
        end
        if (out_data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                 out_data.last_of_run);
          errors++;
        end
        if (out_data.stream_done !== want.stream_done) begin
          $error("stream_done: expected %0b, got %0b", want.stream_done,
                 out_data.stream_done);
          errors++;
        end
        if (out_data.replacements_made !== want.replacements_made) begin
          $error("replacements_made: expected %0d, got %0d", want.replacements_made,
                 out_data.replacements_made);
          errors++;
        end
      end
    end
  end

  initial begin
    int guard;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_MATCH_PATTERN;
    cfg_wdata <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_partial_and_break();
    test_length_limits();
    test_reconfig_drop();
    test_random_streams();

    in_valid <= 1'b0;
    guard = 0;
    while (pending_words.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d words never arrived", pending_words.size());
      errors++;
    end

    $display("Sent %0d bytes in %0d streams under %0d register settings.",
             bytes_sent, streams_closed, settings_used);
    $display("Checked %0d output words; %0d pattern hits predicted.",
             words_checked, swap_count);
    if (errors == 0) begin
      $display("stream_byte_pattern_replace verification clean");
    end else begin
      $display("stream_byte_pattern_replace verification failed");
    end
    $finish;
  end

endmodule
